@@ rtl/keyed_saturating_score_table_macros.svh @@
// Assertion helpers for the score table. Every check is clocked on clk and
// held off while rst_n is low.
`ifndef KEYED_SATURATING_SCORE_TABLE_MACROS_SVH
`define KEYED_SATURATING_SCORE_TABLE_MACROS_SVH

// Check that an expression holds at every clock edge.
`define KSS_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition is followed in the same cycle by a consequence.
`define KSS_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define KSS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/kss_pkg.sv @@
package kss_pkg;

    localparam int OP_W         = 3;
    localparam int GROUP_W      = 2;
    localparam int LOOKUP_KEY_W = 10;
    localparam int SCORE_W      = 15;
    localparam int SLOT_OUT_W   = 6;
    localparam int CFG_INDEX_W  = 2;

    // Request operations
    localparam logic [OP_W-1:0] OP_BUMP    = 3'd0;
    localparam logic [OP_W-1:0] OP_CONFIRM = 3'd1;
    localparam logic [OP_W-1:0] OP_DECAY   = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INCREMENT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CEILING   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR     = 2'd2;

    localparam logic [SCORE_W-1:0] INCREMENT_RESET = 15'd1;
    localparam logic [SCORE_W-1:0] CEILING_RESET   = 15'd100;
    localparam logic [SCORE_W-1:0] FLOOR_RESET     = 15'd50;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [GROUP_W-1:0]      group;
        logic [LOOKUP_KEY_W-1:0] lookup_key;
    } kss_in_t;

    typedef struct packed {
        logic [SCORE_W-1:0]    score;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  replaced;
    } kss_out_t;

endpackage

@@ rtl/kss_ram.sv @@
module kss_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/keyed_saturating_score_table.sv @@
// Keyed saturating score table. GROUP_COUNT groups each hold up to
// SLOTS_PER_GROUP (key, score) entries, filled from slot 0 upward. A request
// names an operation, a group and a key: bump (saturating add of
// score_increment, capped at score_ceiling), confirm (raise to at least
// score_floor_on_confirm), decay (halve), query, or clear all groups. Bump and
// confirm create a missing key with score 0; in a full group they overwrite
// the lowest-score entry, lowest slot on a tie. Every request returns exactly
// one result. All entries sit in one single-port-read RAM with a registered
// read, scanned one slot per cycle; the time a request takes is set by the
// linear scan over the group's used slots through the RAM read port.
// Requests are handled one at a time; the input is ready again as soon as the
// result sits in the output register, even while that result is not yet
// taken. Clear only resets the per-group fill counts, so no sweep of the RAM
// is needed after reset or clear. Configuration writes take effect at once
// and are expected only while no request is in flight.
`include "keyed_saturating_score_table_macros.svh"

module keyed_saturating_score_table #(
    parameter int SLOTS_PER_GROUP = 64,
    parameter int GROUP_COUNT     = 4,
    parameter int KEY_BITS        = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [kss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kss_pkg::SCORE_W-1:0]      cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  kss_pkg::kss_in_t                 in_data,

    output logic                             out_valid,
    input  logic                             out_ready,
    output kss_pkg::kss_out_t                out_data
);

    import kss_pkg::*;

    localparam int DEPTH   = GROUP_COUNT * SLOTS_PER_GROUP;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SW      = $clog2(SLOTS_PER_GROUP);
    localparam int FCW     = $clog2(SLOTS_PER_GROUP + 1);
    localparam int GW      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int ENTRY_W = KEY_BITS + SCORE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Configuration registers
    logic [SCORE_W-1:0] incr_reg;
    logic [SCORE_W-1:0] ceil_reg;
    logic [SCORE_W-1:0] floor_reg;

    // Control and scan state
    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [GROUP_W-1:0]   grp_reg, grp_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [FCW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [SW-1:0]        rd_slot_reg, rd_slot_next;
    logic                 found_reg, found_next;
    logic [SW-1:0]        found_slot_reg, found_slot_next;
    logic [SCORE_W-1:0]   found_score_reg, found_score_next;
    logic [SW-1:0]        min_slot_reg, min_slot_next;
    logic [SCORE_W-1:0]   min_score_reg, min_score_next;
    logic [FCW-1:0]       fill_reg [GROUP_COUNT];
    logic [FCW-1:0]       fill_next [GROUP_COUNT];
    logic                 out_valid_reg, out_valid_next;
    kss_out_t             out_reg, out_next;

    // RAM port
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [ENTRY_W-1:0]   mem_rd_data;

    // Decode of the held request
    logic [GW-1:0]        grp_idx;
    logic                 grp_ok;
    logic                 item_ok;
    logic                 is_update;
    logic                 is_lookup;
    logic [FCW-1:0]       fill_cur;
    logic [FCW-1:0]       scan_len;
    logic                 group_full;
    logic                 out_free;
    logic [KEY_BITS-1:0]  rd_key;
    logic [SCORE_W-1:0]   rd_score;

    // Result arithmetic
    logic [SW-1:0]        tgt_slot;
    logic [SCORE_W-1:0]   old_score;
    logic [SCORE_W:0]     bump_sum;
    logic [SCORE_W-1:0]   bump_score;
    logic [SCORE_W-1:0]   confirm_score;
    logic [SCORE_W-1:0]   new_score;
    logic [SCORE_W-1:0]   decay_score;

    kss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .re      (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Configuration writes land at once; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incr_reg  <= INCREMENT_RESET;
            ceil_reg  <= CEILING_RESET;
            floor_reg <= FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_INCREMENT: incr_reg  <= cfg_data;
                CFG_CEILING:   ceil_reg  <= cfg_data;
                CFG_FLOOR:     floor_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign grp_idx   = GW'(grp_reg);
    assign grp_ok    = 32'(grp_reg) < GROUP_COUNT;
    assign is_update = (op_reg == OP_BUMP) || (op_reg == OP_CONFIRM);
    assign is_lookup = (op_reg == OP_DECAY) || (op_reg == OP_QUERY);
    assign item_ok   = grp_ok && (is_update || is_lookup);
    assign fill_cur  = grp_ok ? fill_reg[grp_idx] : '0;
    // Clear, unused codes and groups out of range scan nothing.
    assign scan_len   = item_ok ? fill_cur : '0;
    assign group_full = fill_cur == FCW'(SLOTS_PER_GROUP);
    assign out_free   = !out_valid_reg || out_ready;

    assign rd_key   = mem_rd_data[ENTRY_W-1 -: KEY_BITS];
    assign rd_score = mem_rd_data[SCORE_W-1:0];

    // Pick the slot the update lands in: the match, the next free slot, or
    // the lowest-score victim of a full group. New entries start from zero.
    always_comb
    begin
        if (found_reg)
        begin
            tgt_slot  = found_slot_reg;
            old_score = found_score_reg;
        end
        else if (!group_full)
        begin
            tgt_slot  = SW'(fill_cur);
            old_score = '0;
        end
        else
        begin
            tgt_slot  = min_slot_reg;
            old_score = '0;
        end
    end

    assign bump_sum      = {1'b0, old_score} + {1'b0, incr_reg};
    // The cap applies even when it lies below the current score.
    assign bump_score    = (bump_sum > {1'b0, ceil_reg}) ? ceil_reg : bump_sum[SCORE_W-1:0];
    assign confirm_score = (old_score < floor_reg) ? floor_reg : old_score;
    assign new_score     = (op_reg == OP_BUMP) ? bump_score : confirm_score;
    assign decay_score   = found_score_reg >> 1;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        grp_next         = grp_reg;
        key_next         = key_reg;
        base_next        = base_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_pend_next     = rd_pend_reg;
        rd_slot_next     = rd_slot_reg;
        found_next       = found_reg;
        found_slot_next  = found_slot_reg;
        found_score_next = found_score_reg;
        min_slot_next    = min_slot_reg;
        min_score_next   = min_score_reg;
        fill_next        = fill_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        mem_we      = 1'b0;
        mem_wr_addr = base_reg + ADDR_W'(tgt_slot);
        mem_wr_data = {key_reg, new_score};
        mem_re      = 1'b0;
        mem_rd_addr = base_reg + ADDR_W'(issue_cnt_reg);

        // Drop the result once the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = in_data.op;
                    grp_next         = in_data.group;
                    key_next         = KEY_BITS'(in_data.lookup_key);
                    base_next        = ADDR_W'(32'(in_data.group) * SLOTS_PER_GROUP);
                    issue_cnt_next   = '0;
                    rd_pend_next     = 1'b0;
                    found_next       = 1'b0;
                    found_slot_next  = '0;
                    found_score_next = '0;
                    min_slot_next    = '0;
                    min_score_next   = '1;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle; its data returns in the following cycle.
                if (issue_cnt_reg < scan_len)
                begin
                    mem_re         = 1'b1;
                    issue_cnt_next = issue_cnt_reg + FCW'(1);
                    rd_pend_next   = 1'b1;
                    rd_slot_next   = SW'(issue_cnt_reg);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    state_next   = S_FINISH;
                end
                if (rd_pend_reg)
                begin
                    // Keep the first match and the first strict minimum.
                    if (!found_reg && (rd_key == key_reg))
                    begin
                        found_next       = 1'b1;
                        found_slot_next  = rd_slot_reg;
                        found_score_next = rd_score;
                    end
                    if (rd_score < min_score_reg)
                    begin
                        min_score_next = rd_score;
                        min_slot_next  = rd_slot_reg;
                    end
                end
            end

            S_FINISH:
            begin
                // Hold until the output register is free, then write back.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    state_next     = S_IDLE;
                    if (op_reg == OP_CLEAR)
                    begin
                        for (int g = 0; g < GROUP_COUNT; g++)
                        begin
                            fill_next[g] = '0;
                        end
                    end
                    else if (item_ok && is_update)
                    begin
                        mem_we            = 1'b1;
                        out_next.score    = new_score;
                        out_next.hit      = found_reg;
                        out_next.slot     = SLOT_OUT_W'(tgt_slot);
                        out_next.replaced = !found_reg && group_full;
                        if (!found_reg && !group_full)
                        begin
                            fill_next[grp_idx] = fill_cur + FCW'(1);
                        end
                    end
                    else if (item_ok && found_reg)
                    begin
                        if (op_reg == OP_DECAY)
                        begin
                            mem_we         = 1'b1;
                            mem_wr_data    = {key_reg, decay_score};
                            out_next.score = decay_score;
                        end
                        else
                        begin
                            out_next.score = found_score_reg;
                        end
                        out_next.hit  = 1'b1;
                        out_next.slot = SLOT_OUT_W'(found_slot_reg);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Requests never overlap, so a write-back always completes before the
    // next request's first read: no forwarding path is needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            grp_reg         <= '0;
            key_reg         <= '0;
            base_reg        <= '0;
            issue_cnt_reg   <= '0;
            rd_pend_reg     <= 1'b0;
            rd_slot_reg     <= '0;
            found_reg       <= 1'b0;
            found_slot_reg  <= '0;
            found_score_reg <= '0;
            min_slot_reg    <= '0;
            min_score_reg   <= '1;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                fill_reg[g] <= '0;
            end
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            grp_reg         <= grp_next;
            key_reg         <= key_next;
            base_reg        <= base_next;
            issue_cnt_reg   <= issue_cnt_next;
            rd_pend_reg     <= rd_pend_next;
            rd_slot_reg     <= rd_slot_next;
            found_reg       <= found_next;
            found_slot_reg  <= found_slot_next;
            found_score_reg <= found_score_next;
            min_slot_reg    <= min_slot_next;
            min_score_reg   <= min_score_next;
            fill_reg        <= fill_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    `KSS_CHECK_NOW(a_scan_bound, (state_reg == S_SCAN), (issue_cnt_reg <= scan_len), "scan read past the group's used slots")
    `KSS_CHECK_NOW(a_pend_in_scan, rd_pend_reg, (state_reg == S_SCAN), "read data pending outside the scan")
    `KSS_CHECK_NEXT(a_finish_loads, (state_reg == S_FINISH && out_free), (out_valid_reg && state_reg == S_IDLE), "finished request produced no result")
    `KSS_CHECK(a_hit_not_replaced, !(out_valid_reg && out_reg.hit && out_reg.replaced), "result flags both hit and replacement")

endmodule
